/* rtl/core/assert_macros.svh */
// Assertion macros shared by the meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

/* rtl/core/ssnr_pkg.sv */
package ssnr_pkg;
	localparam int unsigned DbPerLog2Q16 = 197283;
	localparam int unsigned FrameLenReset = 160;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_FLOG_S,
		ST_FLOG_E,
		ST_FMUL,
		ST_FSUM,
		ST_TLOG_S,
		ST_TLOG_E,
		ST_TMUL,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] value;
	} log_req_t;

	typedef struct packed {
		logic        done;
		logic [21:0] result;
	} log_rsp_t;
endpackage

/* rtl/core/ssnr_log2.sv */
module ssnr_log2
	import ssnr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  log_req_t req,
	output log_rsp_t rsp
);
	logic [63:0] norm_q;
	logic [5:0]  msb_q;
	logic [32:0] m_q;
	logic [15:0] frac_q;
	logic [4:0]  cnt_q;
	logic [1:0]  phase_q;
	logic [65:0] sq;
	logic [34:0] sqs;

	assign sq  = {33'd0, m_q} * {33'd0, m_q};
	assign sqs = sq[65:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			cnt_q   <= 5'd0;
		end else begin
			case (phase_q)
				2'd0: if (req.start) begin
					norm_q  <= req.value;
					msb_q   <= 6'd63;
					phase_q <= 2'd1;
				end
				2'd1: begin
					if (norm_q[63] || msb_q == 6'd0) begin
						m_q     <= {1'b0, norm_q[63:32]};
						frac_q  <= 16'd0;
						cnt_q   <= 5'd0;
						phase_q <= 2'd2;
					end else begin
						norm_q <= norm_q << 1;
						msb_q  <= msb_q - 6'd1;
					end
				end
				2'd2: begin
					if (sqs[32]) begin
						m_q    <= sqs[33:1];
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						m_q    <= sqs[32:0];
						frac_q <= {frac_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) phase_q <= 2'd3;
				end
				default: phase_q <= 2'd0;
			endcase
		end
	end

	assign rsp.done   = (phase_q == 2'd3);
	assign rsp.result = {msb_q, frac_q};
endmodule

/* rtl/core/segmental_snr_meter.sv */
// Segmental SNR meter.
// Input stream s_axis: tdata = {processed_sample, original_sample}, tlast marks the
// final pair of a signal. Output stream m_axis: tdata = {segmental_snr_db, snr_db},
// tuser = {saturated, segment_valid}, one transaction per signal on its last pair.
// cfg_valid/cfg_ready write frame_length while the block is idle.
// Each accepted pair is squared, then summed in the accumulate state. Closing a frame
// adds two log2 runs of the shared log unit and a multiply; the last pair adds two
// more log runs, a multiply and a restoring divide; a zero energy skips its log runs.
// Reset clears all accumulators and sets frame_length to 160.
// A finished result waits in the output register; no new pair is accepted until
// it has been taken, so a stalled receiver stalls the input.
`include "assert_macros.svh"
module segmental_snr_meter
	import ssnr_pkg::*;
#(
	parameter int MAX_FRAME_LENGTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // original_sample, processed_sample
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // snr_db, segmental_snr_db
	output logic [1:0]  m_axis_tuser,  // segment_valid, saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data
);
	localparam int PosW = $clog2(MAX_FRAME_LENGTH + 1);
	localparam logic [63:0] MaxLen = 64'(MAX_FRAME_LENGTH);

	state_t state_q, state_d;
	logic [12:0] flen_q;
	logic [63:0] tse_q, tee_q;
	logic [47:0] fse_q, fee_q, dbsum_q;
	logic [PosW-1:0] pos_q;
	logic [31:0] fcnt_q;
	logic sat_q, last_q, osat_q, seg_v_q;
	logic [31:0] sx_q, se_q;
	logic [21:0] logs_q;
	logic [15:0] snr_q, seg_q;
	logic        mvalid_q;
	logic [47:0] rem_q, quo_q, dmag_q;
	logic [5:0]  dcnt_q;
	logic        dneg_q;
	logic [22:0] diff_q;
	logic [63:0] prod_s1;
	logic        rsel_q;
	logic        special_q;
	logic [15:0] special_val_q;

	log_req_t lreq;
	log_rsp_t lrsp;

	ssnr_log2 u_log (.clk(clk), .arst_n(arst_n), .req(lreq), .rsp(lrsp));

	logic signed [15:0] x, y;
	logic signed [16:0] err;
	logic [16:0] ax, ae;
	logic [PosW-1:0] len;
	logic [64:0] tsum_s, tsum_e;
	logic [48:0] fsum_s, fsum_e;

	assign x   = s_axis_tdata[15:0];
	assign y   = s_axis_tdata[31:16];
	assign err = 17'(x) - 17'(y);
	assign ax  = x[15] ? 17'(-17'(x)) : 17'(x);
	assign ae  = err[16] ? 17'(-err) : 17'(err);

	always_comb begin
		if (flen_q == 13'd0) len = PosW'(1);
		else if (64'(flen_q) > MaxLen) len = PosW'(MAX_FRAME_LENGTH);
		else len = PosW'(flen_q);
	end

	assign tsum_s = {1'b0, tse_q} + 65'(sx_q);
	assign tsum_e = {1'b0, tee_q} + 65'(se_q);
	assign fsum_s = {1'b0, fse_q} + 49'(sx_q);
	assign fsum_e = {1'b0, fee_q} + 49'(se_q);

	assign s_axis_tready = (state_q == ST_IDLE) && !mvalid_q;
	assign cfg_ready     = (state_q == ST_IDLE);
	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = {seg_q, snr_q};
	assign m_axis_tuser  = {osat_q, seg_v_q};

	// Rounded dB from product; special ratios bypass.
	logic [63:0] pmag;
	logic [39:0] q8;
	logic signed [40:0] rdb;
	assign pmag = prod_s1[63] ? 64'(-prod_s1) : prod_s1;
	assign q8   = 40'((pmag + 64'd8388608) >> 24);
	assign rdb  = special_q ? 41'(signed'(special_val_q))
		: (prod_s1[63] ? -41'(q8) : 41'(q8));

	logic signed [49:0] nsum;
	assign nsum = 50'(signed'(dbsum_q)) + 50'(rdb);

	logic [48:0] trial;
	assign trial = {rem_q, quo_q[47]} - {17'd0, fcnt_q};

	always_comb begin
		state_d     = state_q;
		lreq.start  = 1'b0;
		lreq.value  = rsel_q ? tee_q : tse_q;
		unique case (state_q)
			ST_IDLE:   if (s_axis_tvalid && s_axis_tready) state_d = ST_ACC;
			ST_ACC:    state_d = (64'(pos_q) + 64'd1 >= 64'(len)) ? ST_FLOG_S
				: (last_q ? ST_TLOG_S : ST_IDLE);
			ST_FLOG_S: begin
				lreq.value = rsel_q ? {16'd0, fee_q} : {16'd0, fse_q};
				lreq.start = !special_q;
				if (special_q) state_d = ST_FSUM;
				else if (lrsp.done) state_d = rsel_q ? ST_FMUL : ST_FLOG_S;
			end
			ST_FLOG_E: state_d = ST_FMUL;
			ST_FMUL:   state_d = ST_FSUM;
			ST_FSUM:   state_d = last_q ? ST_TLOG_S : ST_IDLE;
			ST_TLOG_S: begin
				lreq.start = !special_q;
				if (special_q) state_d = ST_DIV;
				else if (lrsp.done) state_d = rsel_q ? ST_TMUL : ST_TLOG_S;
			end
			ST_TLOG_E: state_d = ST_TMUL;
			ST_TMUL:   state_d = ST_DIV;
			ST_DIV:    if (dcnt_q == 6'd49) state_d = ST_OUT;
			ST_OUT:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q   <= 13'(FrameLenReset);
			tse_q    <= '0; tee_q <= '0; fse_q <= '0; fee_q <= '0;
			pos_q    <= '0; dbsum_q <= '0; fcnt_q <= '0; sat_q <= 1'b0;
			mvalid_q <= 1'b0; rsel_q <= 1'b0; special_q <= 1'b0;
			last_q   <= 1'b0; dcnt_q <= '0;
		end else begin
			if (mvalid_q && m_axis_tready) mvalid_q <= 1'b0;
			if (cfg_valid && cfg_ready) flen_q <= cfg_data;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					sx_q   <= 32'(ax) * 32'(ax);
					se_q   <= 32'(ae) * 32'(ae);
					last_q <= s_axis_tlast;
				end
				ST_ACC: begin
					tse_q <= tsum_s[64] ? '1 : tsum_s[63:0];
					tee_q <= tsum_e[64] ? '1 : tsum_e[63:0];
					if (64'(pos_q) + 64'd1 >= 64'(len)) begin
						pos_q  <= '0;
						fse_q  <= fsum_s[48] ? '1 : fsum_s[47:0];
						fee_q  <= fsum_e[48] ? '1 : fsum_e[47:0];
						rsel_q <= 1'b0;
						special_q <= (fsum_s == '0) || (fsum_e == '0);
						if ((fsum_s == '0) || (fsum_e == '0)) begin
							sat_q <= 1'b1;
							special_val_q <= (fsum_s == '0 && fsum_e == '0) ? 16'd0
								: ((fsum_e == '0) ? 16'h7FFF : 16'h8000);
						end
					end else begin
						pos_q <= pos_q + PosW'(1);
						fse_q <= fsum_s[48] ? '1 : fsum_s[47:0];
						fee_q <= fsum_e[48] ? '1 : fsum_e[47:0];
						if (last_q) begin
							rsel_q <= 1'b0;
							special_q <= (tsum_s == '0) || (tsum_e == '0);
							osat_q <= sat_q || (tsum_s == '0) || (tsum_e == '0);
							special_val_q <= (tsum_s == '0 && tsum_e == '0) ? 16'd0
								: ((tsum_e == '0) ? 16'h7FFF : 16'h8000);
						end
					end
				end
				ST_FLOG_S, ST_TLOG_S: if (lrsp.done && !special_q) begin
					if (!rsel_q) begin
						logs_q <= lrsp.result;
						rsel_q <= 1'b1;
					end else begin
						diff_q <= 23'(logs_q) - 23'(lrsp.result);
					end
				end
				ST_FMUL, ST_TMUL: prod_s1 <= 64'(signed'(diff_q)) * 64'(DbPerLog2Q16);
				default: ;
			endcase
			if (state_q == ST_FSUM) begin
				fse_q <= '0;
				fee_q <= '0;
				if (nsum > 50'sh7FFFFFFFFFFF) dbsum_q <= 48'h7FFFFFFFFFFF;
				else if (nsum < -50'sh800000000000) dbsum_q <= 48'h800000000000;
				else dbsum_q <= nsum[47:0];
				if (fcnt_q != '1) fcnt_q <= fcnt_q + 32'd1;
				if (last_q) begin
					rsel_q <= 1'b0;
					special_q <= (tse_q == '0) || (tee_q == '0);
					osat_q <= sat_q || (tse_q == '0) || (tee_q == '0);
					special_val_q <= (tse_q == '0 && tee_q == '0) ? 16'd0
						: ((tee_q == '0) ? 16'h7FFF : 16'h8000);
				end
			end
			if ((state_q == ST_TMUL) || (state_q == ST_TLOG_S && special_q)) begin
				dneg_q <= dbsum_q[47];
				dmag_q <= dbsum_q[47] ? 48'(-dbsum_q) : dbsum_q;
				dcnt_q <= '0;
			end
			if (state_q == ST_DIV) begin
				dcnt_q <= dcnt_q + 6'd1;
				if (dcnt_q == 6'd0) begin
					snr_q <= (rdb > 41'sd32767) ? 16'h7FFF
						: ((rdb < -41'sd32768) ? 16'h8000 : rdb[15:0]);
					rem_q <= '0;
					quo_q <= dmag_q + 48'(fcnt_q >> 1);
				end else if (dcnt_q <= 6'd48) begin
					if (!trial[48]) begin
						rem_q <= trial[47:0];
						quo_q <= {quo_q[46:0], 1'b1};
					end else begin
						rem_q <= {rem_q[46:0], quo_q[47]};
						quo_q <= {quo_q[46:0], 1'b0};
					end
				end
			end
			if (state_q == ST_OUT) begin
				seg_v_q <= (fcnt_q != '0);
				if (fcnt_q == '0) seg_q <= 16'd0;
				else if (quo_q > 48'd32767 && !dneg_q) seg_q <= 16'h7FFF;
				else if (quo_q > 48'd32768 && dneg_q) seg_q <= 16'h8000;
				else seg_q <= dneg_q ? 16'(-quo_q[15:0]) : quo_q[15:0];
				mvalid_q <= 1'b1;
				tse_q <= '0; tee_q <= '0; fse_q <= '0; fee_q <= '0;
				pos_q <= '0; dbsum_q <= '0; fcnt_q <= '0; sat_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`ASSERT_IMPL(a_no_input_while_full, clk, arst_n, !(s_axis_tready && m_axis_tvalid))
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

/* sim/segmental_snr_checker.sv */
module segmental_snr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // original_sample, processed_sample
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,  // snr_db, segmental_snr_db
	input  logic [1:0]  m_axis_tuser,  // segment_valid, saturated
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [12:0] cfg_data,
	output int          pending,
	output int          errors
);
	localparam int unsigned MaxFrame = 4096;
	localparam longint unsigned FrameEnergyMax = 64'h0000_FFFF_FFFF_FFFF;
	localparam longint DbSumMax = 64'sd140737488355327;
	localparam longint DbSumMin = -64'sd140737488355328;

	typedef struct packed {
		logic signed [15:0] snr_db;
		logic signed [15:0] segmental_snr_db;
		logic               segment_valid;
		logic               saturated;
	} meter_result_t;

	meter_result_t   expected_results[$];
	logic [12:0]     frame_length;
	longint unsigned total_signal, total_error, frame_signal, frame_error;
	int unsigned     frame_position, frame_count;
	longint          db_sum;
	bit              saturation_seen;

	assign pending = expected_results.size();

	function automatic longint log2_q16(longint unsigned v);
		int msb;
		longint unsigned m;
		longint frac;
		msb = 63;
		frac = 0;
		while (msb > 0 && v[msb] == 1'b0)
			msb--;
		m = (v << (63 - msb)) >> 32;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (longint'(msb) << 16) | frac;
	endfunction

	function automatic longint energy_ratio_db(longint unsigned s, longint unsigned e,
			output bit special);
		longint prod, mag, q;
		special = (s == 0 || e == 0);
		if (s == 0 && e == 0)
			return 0;
		if (e == 0)
			return 32767;
		if (s == 0)
			return -32768;
		prod = (log2_q16(s) - log2_q16(e)) * longint'(197283);
		mag = prod < 0 ? -prod : prod;
		q = (mag + (64'sd1 <<< 23)) >>> 24;
		return prod < 0 ? -q : q;
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic longint unsigned add_sat64(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
	endfunction

	function automatic longint unsigned add_sat48(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s > FrameEnergyMax) ? FrameEnergyMax : s;
	endfunction

	task automatic clear_energies();
		total_signal = 0;
		total_error = 0;
		frame_signal = 0;
		frame_error = 0;
		frame_position = 0;
		db_sum = 0;
		frame_count = 0;
		saturation_seen = 0;
	endtask

	task automatic predict_pair(logic [15:0] orig, logic [15:0] proc, logic last);
		int              x, y, err;
		longint unsigned sx, se;
		int unsigned     len;
		longint          sum, mag, q;
		bit              special;
		meter_result_t   r;
		x = int'(signed'(orig));
		y = int'(signed'(proc));
		err = x - y;
		sx = longint'(x) * longint'(x);
		se = longint'(err) * longint'(err);
		len = frame_length;
		if (len == 0)
			len = 1;
		if (len > MaxFrame)
			len = MaxFrame;
		total_signal = add_sat64(total_signal, sx);
		total_error = add_sat64(total_error, se);
		frame_signal = add_sat48(frame_signal, sx);
		frame_error = add_sat48(frame_error, se);
		frame_position++;
		if (frame_position >= len) begin
			sum = db_sum + energy_ratio_db(frame_signal, frame_error, special);
			if (special)
				saturation_seen = 1;
			if (sum > DbSumMax)
				sum = DbSumMax;
			if (sum < DbSumMin)
				sum = DbSumMin;
			db_sum = sum;
			if (frame_count != 32'hFFFF_FFFF)
				frame_count++;
			frame_signal = 0;
			frame_error = 0;
			frame_position = 0;
		end
		if (!last)
			return;
		r.snr_db = clamp16(energy_ratio_db(total_signal, total_error, special));
		r.saturated = saturation_seen | special;
		r.segmental_snr_db = '0;
		r.segment_valid = frame_count != 0;
		if (frame_count != 0) begin
			mag = db_sum < 0 ? -db_sum : db_sum;
			q = (mag + longint'(frame_count / 2)) / longint'(frame_count);
			r.segmental_snr_db = clamp16(db_sum < 0 ? -q : q);
		end
		expected_results.push_back(r);
		clear_energies();
	endtask

	always @(posedge clk or negedge arst_n) begin
		meter_result_t exp_r, got;
		if (!arst_n) begin
			frame_length <= 13'd160;
			clear_energies();
			expected_results.delete();
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				frame_length <= cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				predict_pair(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got.snr_db = m_axis_tdata[15:0];
				got.segmental_snr_db = m_axis_tdata[31:16];
				got.segment_valid = m_axis_tuser[0];
				got.saturated = m_axis_tuser[1];
				if (expected_results.size() == 0) begin
					if (errors < 10)
						$display("Unexpected result transaction: %p", got);
					errors <= errors + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						if (errors < 10)
							$display("Mismatch: expected %p, actual %p", exp_r, got);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

/* sim/tb_segmental_snr_meter.sv */
module tb_segmental_snr_meter;
	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // original_sample, processed_sample
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // snr_db, segmental_snr_db
	logic [1:0]  m_axis_tuser;  // segment_valid, saturated
	logic        cfg_valid;
	logic        cfg_ready;
	logic [12:0] cfg_data;
	int          pending;
	int          errors;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          pair_count;
	int          signal_count;
	int          cfg_count;

	segmental_snr_meter dut (.*);

	segmental_snr_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("tb_segmental_snr_meter NOT OK");
		$finish;
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

	task automatic send_pair(logic [15:0] x, logic [15:0] y, logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pair_count++;
		if (last)
			signal_count++;
	endtask

	task automatic stop_and_drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (400)
			@(posedge clk);
	endtask

	task automatic write_frame_length(logic [12:0] v);
		stop_and_drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_count++;
	endtask

	task automatic random_pair(output logic [15:0] x, output logic [15:0] y);
		logic [15:0] corner[4];
		corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		x = $urandom;
		y = $urandom;
		case ($urandom_range(9))
			0, 1: ;
			2: y = x;
			3: x = '0;
			4: begin
				x = '0;
				y = '0;
			end
			5: begin
				x = corner[$urandom_range(3)];
				y = corner[$urandom_range(3)];
			end
			default: y = x + 16'($urandom_range(64)) - 16'd32;
		endcase
	endtask

	task automatic random_signal(int unsigned len);
		logic [15:0] x, y;
		for (int i = 1; i <= len; i++) begin
			random_pair(x, y);
			send_pair(x, y, i == len);
		end
	endtask

	initial begin
		int used;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tlast = 0;
		m_axis_tready = 0;
		cfg_valid = 0;
		cfg_data = '0;
		tx_idle_pct = 17;
		rx_idle_pct = 78;
		pair_count = 0;
		signal_count = 0;
		cfg_count = 0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(16'h7FFF, 16'h7FFF, 1'b1);
		send_pair(16'h0000, 16'h0005, 1'b1);
		send_pair(16'h0000, 16'h0000, 1'b1);
		send_pair(16'h8000, 16'h7FFF, 1'b1);
		send_pair(16'd100, 16'd90, 1'b0);
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		write_frame_length(13'd1);
		send_pair(16'd1000, 16'd1000, 1'b0);
		send_pair(16'h0000, 16'd7, 1'b0);
		send_pair(16'd300, 16'd299, 1'b0);
		send_pair(16'hFF00, 16'hFF10, 1'b1);
		write_frame_length(13'd0);
		send_pair(16'd12, 16'd10, 1'b0);
		send_pair(16'd5000, 16'd4000, 1'b1);
		write_frame_length(13'h1FFF);
		send_pair(16'd5, 16'd1, 1'b0);
		send_pair(16'd9, 16'd2, 1'b1);
		write_frame_length(13'd2);
		send_pair(16'd20000, 16'd19000, 1'b0);
		send_pair(16'hB000, 16'hB100, 1'b0);
		send_pair(16'd1, 16'd2, 1'b1);

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 78 : 0;
			rx_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 17 : 0;
			for (int k = 0; k < 4; k++) begin
				case ($urandom_range(7))
					0: write_frame_length(13'd0);
					1: write_frame_length(13'h1FFF);
					2: write_frame_length(13'd160);
					3: write_frame_length(13'd4096);
					default: write_frame_length(13'($urandom_range(1, 12)));
				endcase
				used = 0;
				while (used < 30) begin
					int unsigned n;
					n = $urandom_range(1, 30);
					random_signal(n);
					used += n;
				end
			end
		end

		stop_and_drain();
		$display("Covered %0d sample pairs in %0d signals with %0d frame length writes.",
			pair_count, signal_count, cfg_count);
		if (errors == 0)
			$display("tb_segmental_snr_meter OK");
		else
			$display("tb_segmental_snr_meter NOT OK");
		$finish;
	end
endmodule
